// ----- hw/rtl/wgvs_pkg.sv -----
// wgvs_pkg: shared types, widths and constants for the wind gust vector sum
// holds the cordic arctangent table and fixed-point scale factors
// no dependencies
`timescale 1ns / 1ps

package wgvs_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int NSTEPS       = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int STEP_W       = 5;

    // rotation lanes, vectoring lanes, angle accumulator
    localparam int RW = 28;
    localparam int VW = 32;
    localparam int ZW = 35;

    localparam logic [29:0]          KINV_Q30    = 30'd652032874;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [ZW-1:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [17:0]   AZ_LIMIT    = 18'sd25736;

    typedef enum logic [2:0] {
        REG_STEADY_SPEED   = 3'd0,
        REG_STEADY_AZIMUTH = 3'd1,
        REG_GUST_SPEED     = 3'd2,
        REG_GUST_AZIMUTH   = 3'd3,
        REG_GUST_START     = 3'd4,
        REG_GUST_LENGTH    = 3'd5
    } cfg_index_t;

    function automatic logic signed [ZW-1:0] atan_q30(input logic [STEP_W-1:0] i);
        logic signed [ZW-1:0] r;
        unique case (i)
            5'd0:  r = 35'sd843314856;
            5'd1:  r = 35'sd497837829;
            5'd2:  r = 35'sd263043836;
            5'd3:  r = 35'sd133525158;
            5'd4:  r = 35'sd67021686;
            5'd5:  r = 35'sd33543515;
            5'd6:  r = 35'sd16775850;
            5'd7:  r = 35'sd8388437;
            5'd8:  r = 35'sd4194282;
            5'd9:  r = 35'sd2097149;
            5'd10: r = 35'sd1048575;
            5'd11: r = 35'sd524287;
            5'd12: r = 35'sd262143;
            5'd13: r = 35'sd131071;
            5'd14: r = 35'sd65535;
            5'd15: r = 35'sd32767;
            5'd16: r = 35'sd16383;
            5'd17: r = 35'sd8191;
            5'd18: r = 35'sd4095;
            5'd19: r = 35'sd2047;
            5'd20: r = 35'sd1023;
            5'd21: r = 35'sd511;
            5'd22: r = 35'sd255;
            5'd23: r = 35'sd127;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- hw/rtl/wgvs_rot_step.sv -----
// wgvs_rot_step: one registered cordic rotation step (sin/cos generation)
// depends on wgvs_pkg
`timescale 1ns / 1ps

module wgvs_rot_step
    import wgvs_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic [STEP_W-1:0]        step,
    input  logic signed [RW-1:0]     c_in,
    input  logic signed [RW-1:0]     s_in,
    input  logic signed [ZW-1:0]     z_in,
    output logic signed [RW-1:0]     c_out,
    output logic signed [RW-1:0]     s_out,
    output logic signed [ZW-1:0]     z_out
);

    logic signed [RW-1:0] c_reg, c_next;
    logic signed [RW-1:0] s_reg, s_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic signed [RW-1:0] dc;
    logic signed [RW-1:0] ds;

    always_comb
    begin
        dc = s_in >>> step;
        ds = c_in >>> step;
        if (z_in >= 0)
        begin
            c_next = c_in - dc;
            s_next = s_in + ds;
            z_next = z_in - atan_q30(step);
        end
        else
        begin
            c_next = c_in + dc;
            s_next = s_in - ds;
            z_next = z_in + atan_q30(step);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg <= c_next;
            s_reg <= s_next;
            z_reg <= z_next;
        end
    end

    assign c_out = c_reg;
    assign s_out = s_reg;
    assign z_out = z_reg;

endmodule

// ----- hw/rtl/wgvs_vec_step.sv -----
// wgvs_vec_step: one registered cordic vectoring step (magnitude and atan2)
// depends on wgvs_pkg
`timescale 1ns / 1ps

module wgvs_vec_step
    import wgvs_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic [STEP_W-1:0]        step,
    input  logic signed [VW-1:0]     px_in,
    input  logic signed [VW-1:0]     py_in,
    input  logic signed [ZW-1:0]     z_in,
    output logic signed [VW-1:0]     px_out,
    output logic signed [VW-1:0]     py_out,
    output logic signed [ZW-1:0]     z_out
);

    logic signed [VW-1:0] px_reg, px_next;
    logic signed [VW-1:0] py_reg, py_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic signed [VW-1:0] dx;
    logic signed [VW-1:0] dy;

    always_comb
    begin
        dx = py_in >>> step;
        dy = px_in >>> step;
        if (py_in >= 0)
        begin
            px_next = px_in + dx;
            py_next = py_in - dy;
            z_next  = z_in + atan_q30(step);
        end
        else
        begin
            px_next = px_in - dx;
            py_next = py_in + dy;
            z_next  = z_in - atan_q30(step);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
            z_reg  <= z_next;
        end
    end

    assign px_out = px_reg;
    assign py_out = py_reg;
    assign z_out  = z_reg;

endmodule

// ----- hw/rtl/wind_gust_vector_sum.sv -----
// wind_gust_vector_sum: steady wind plus timed gust, summed as one vector
// depends on wgvs_pkg, wgvs_rot_step and wgvs_vec_step
//
// usage: each transfer on the slave stream carries one simulation time stamp in ms.
// one result per time stamp leaves on the master stream: tdata holds total speed
// (q8.8, saturating), total azimuth (q3.13) and the echoed stamp; tuser is the
// gust flag. registers are written through cfg_we/cfg_addr/cfg_wdata while idle.
// the pipeline has 2*NSTEPS+4 register stages (36 with 16 cordic steps): one setup
// stage, NSTEPS rotation stages, one summing stage, NSTEPS vectoring stages and two
// output scaling stages. one stamp is taken per cycle unless the master side stalls.
// each stage has its own valid bit and loads whenever it is empty or its
// successor loads, so a stall at the master side fills bubbles first and
// loses nothing. reset clears all valid bits and the configuration registers.
`timescale 1ns / 1ps

module wind_gust_vector_sum
    import wgvs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // sim_time_ms
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // total_speed, total_azimuth, stamp_ms
    output logic        m_axis_tuser    // gust_active
);

    localparam int L      = 2 * NSTEPS + 4;
    localparam int S_SUM  = NSTEPS + 1;
    localparam int S_MUL  = 2 * NSTEPS + 2;
    localparam int S_OUT  = 2 * NSTEPS + 3;

    logic signed [15:0] steady_speed_reg;
    logic signed [15:0] steady_azimuth_reg;
    logic signed [15:0] gust_speed_reg;
    logic signed [15:0] gust_azimuth_reg;
    logic [31:0]        gust_start_reg;
    logic [31:0]        gust_length_reg;

    logic               vld_reg [0:L-1];
    logic               en [0:L];
    logic [31:0]        t_reg [0:L-1];
    logic               act_reg [0:L-1];
    logic               zero_reg [0:L-1];

    logic signed [RW-1:0] st_c [0:NSTEPS];
    logic signed [RW-1:0] st_s [0:NSTEPS];
    logic signed [ZW-1:0] st_z [0:NSTEPS];
    logic signed [RW-1:0] gu_c [0:NSTEPS];
    logic signed [RW-1:0] gu_s [0:NSTEPS];
    logic signed [ZW-1:0] gu_z [0:NSTEPS];
    logic signed [VW-1:0] v_px [0:NSTEPS];
    logic signed [VW-1:0] v_py [0:NSTEPS];
    logic signed [ZW-1:0] v_z  [0:NSTEPS];

    logic signed [RW-1:0] st_c_reg, gu_c_reg;
    logic signed [ZW-1:0] st_z_reg, gu_z_reg;
    logic signed [RW-1:0] st_c_next, gu_c_next;
    logic signed [ZW-1:0] st_z_next, gu_z_next;
    logic                 act_next;

    logic signed [VW-1:0] px_reg, px_next;
    logic signed [VW-1:0] py_reg, py_next;
    logic signed [ZW-1:0] vz_reg, vz_next;
    logic                 zero_next;

    logic [60:0]          prod_reg, prod_next;
    logic signed [17:0]   az_reg, az_next;
    logic [15:0]          speed_reg, speed_next;
    logic signed [15:0]   az_out_reg;

    function automatic logic signed [RW-1:0] scale_speed(input logic signed [15:0] v);
        logic signed [46:0] p;
        logic signed [46:0] r;
        p = v * $signed({1'b0, KINV_Q30});
        r = p + 47'sd2097152;
        return RW'(r >>> 22);
    endfunction

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steady_speed_reg   <= '0;
            steady_azimuth_reg <= '0;
            gust_speed_reg     <= '0;
            gust_azimuth_reg   <= '0;
            gust_start_reg     <= '0;
            gust_length_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_addr))
                REG_STEADY_SPEED:   steady_speed_reg   <= cfg_wdata[15:0];
                REG_STEADY_AZIMUTH: steady_azimuth_reg <= cfg_wdata[15:0];
                REG_GUST_SPEED:     gust_speed_reg     <= cfg_wdata[15:0];
                REG_GUST_AZIMUTH:   gust_azimuth_reg   <= cfg_wdata[15:0];
                REG_GUST_START:     gust_start_reg     <= cfg_wdata;
                REG_GUST_LENGTH:    gust_length_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // stage enables
    always_comb
    begin
        en[L] = m_axis_tready;
        for (int k = L - 1; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < L; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            for (int k = 0; k < L; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= (k == 0) ? s_axis_tvalid : vld_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    // stamp, gust flag and zero flag travel with each item
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < L; k++)
        begin
            if (en[k])
            begin
                if (k == 0)
                begin
                    t_reg[k]    <= s_axis_tdata;
                    act_reg[k]  <= act_next;
                    zero_reg[k] <= 1'b0;
                end
                else
                begin
                    t_reg[k]    <= t_reg[k-1];
                    act_reg[k]  <= act_reg[k-1];
                    zero_reg[k] <= (k == S_SUM) ? zero_next : zero_reg[k-1];
                end
            end
        end
    end

    // setup stage: gust window, start vectors and quadrant reduction
    always_comb
    begin
        logic signed [ZW-1:0] zs;
        logic signed [ZW-1:0] zg;
        logic signed [RW-1:0] cs;
        logic signed [RW-1:0] cg;
        act_next = (s_axis_tdata >= gust_start_reg)
                && ({1'b0, s_axis_tdata} < ({1'b0, gust_start_reg} + {1'b0, gust_length_reg}));
        cs = scale_speed(steady_speed_reg);
        cg = scale_speed(gust_speed_reg);
        zs = {{(ZW - 33){steady_azimuth_reg[15]}}, steady_azimuth_reg, 17'b0};
        zg = {{(ZW - 33){gust_azimuth_reg[15]}}, gust_azimuth_reg, 17'b0};
        st_z_next = zs;
        st_c_next = cs;
        if (zs > HALF_PI_Q30)
        begin
            st_z_next = zs - PI_Q30;
            st_c_next = -cs;
        end
        else if (zs < -HALF_PI_Q30)
        begin
            st_z_next = zs + PI_Q30;
            st_c_next = -cs;
        end
        gu_z_next = zg;
        gu_c_next = cg;
        if (zg > HALF_PI_Q30)
        begin
            gu_z_next = zg - PI_Q30;
            gu_c_next = -cg;
        end
        else if (zg < -HALF_PI_Q30)
        begin
            gu_z_next = zg + PI_Q30;
            gu_c_next = -cg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            st_c_reg <= st_c_next;
            st_z_reg <= st_z_next;
            gu_c_reg <= gu_c_next;
            gu_z_reg <= gu_z_next;
        end
    end

    assign st_c[0] = st_c_reg;
    assign st_s[0] = '0;
    assign st_z[0] = st_z_reg;
    assign gu_c[0] = gu_c_reg;
    assign gu_s[0] = '0;
    assign gu_z[0] = gu_z_reg;

    for (genvar i = 0; i < NSTEPS; i++)
    begin : g_rot
        wgvs_rot_step u_rot_steady (
            .clk   (clk),
            .en    (en[i+1]),
            .step  (STEP_W'(i)),
            .c_in  (st_c[i]),
            .s_in  (st_s[i]),
            .z_in  (st_z[i]),
            .c_out (st_c[i+1]),
            .s_out (st_s[i+1]),
            .z_out (st_z[i+1])
        );
        wgvs_rot_step u_rot_gust (
            .clk   (clk),
            .en    (en[i+1]),
            .step  (STEP_W'(i)),
            .c_in  (gu_c[i]),
            .s_in  (gu_s[i]),
            .z_in  (gu_z[i]),
            .c_out (gu_c[i+1]),
            .s_out (gu_s[i+1]),
            .z_out (gu_z[i+1])
        );
    end

    // summing stage and half-plane fold for vectoring
    always_comb
    begin
        logic signed [VW-1:0] sx;
        logic signed [VW-1:0] cy;
        sx = VW'(st_s[NSTEPS]);
        cy = VW'(st_c[NSTEPS]);
        if (act_reg[S_SUM-1])
        begin
            sx = sx + VW'(gu_s[NSTEPS]);
            cy = cy + VW'(gu_c[NSTEPS]);
        end
        zero_next = (sx == '0) && (cy == '0);
        px_next = cy;
        py_next = sx;
        vz_next = '0;
        if (cy < 0)
        begin
            vz_next = (sx >= 0) ? PI_Q30 : -PI_Q30;
            px_next = -cy;
            py_next = -sx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[S_SUM])
        begin
            px_reg <= px_next;
            py_reg <= py_next;
            vz_reg <= vz_next;
        end
    end

    assign v_px[0] = px_reg;
    assign v_py[0] = py_reg;
    assign v_z[0]  = vz_reg;

    for (genvar j = 0; j < NSTEPS; j++)
    begin : g_vec
        wgvs_vec_step u_vec (
            .clk    (clk),
            .en     (en[S_SUM+1+j]),
            .step   (STEP_W'(j)),
            .px_in  (v_px[j]),
            .py_in  (v_py[j]),
            .z_in   (v_z[j]),
            .px_out (v_px[j+1]),
            .py_out (v_py[j+1]),
            .z_out  (v_z[j+1])
        );
    end

    // gain correction product and angle rounding
    always_comb
    begin
        logic [30:0]          pxu;
        logic signed [ZW-1:0] zr;
        logic signed [17:0]   a;
        pxu = (v_px[NSTEPS] < 0) ? '0 : v_px[NSTEPS][30:0];
        prod_next = pxu * KINV_Q30;
        zr = v_z[NSTEPS] + 35'sd65536;
        a = 18'(zr >>> 17);
        if (a > AZ_LIMIT)
        begin
            az_next = AZ_LIMIT;
        end
        else if (a < -AZ_LIMIT)
        begin
            az_next = -AZ_LIMIT;
        end
        else
        begin
            az_next = a;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[S_MUL])
        begin
            prod_reg <= prod_next;
            az_reg   <= az_next;
        end
    end

    always_comb
    begin
        logic [61:0] r;
        logic [23:0] q;
        r = {1'b0, prod_reg} + 62'd137438953472;
        q = r[61:38];
        speed_next = (q > 24'd65535) ? 16'hFFFF : q[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[S_OUT])
        begin
            speed_reg  <= zero_reg[S_MUL] ? '0 : speed_next;
            az_out_reg <= zero_reg[S_MUL] ? '0 : az_reg[15:0];
        end
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = vld_reg[L-1];
    assign m_axis_tdata  = {t_reg[L-1], az_out_reg, speed_reg};
    assign m_axis_tuser  = act_reg[L-1];

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output stage");

    a_accept_loads_first: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> vld_reg[0])
        else $error("accepted transfer not held in first stage");

    a_azimuth_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[31:16]) <= 16'sd25736)
                       && ($signed(m_axis_tdata[31:16]) >= -16'sd25736))
        else $error("azimuth out of range");

endmodule

// ----- tb/sv/tb_top.sv -----
// tb_top: self-checking testbench for wind_gust_vector_sum
// directed table then random phases, results checked against typed expectations or a cordic wind predictor
// depends on wgvs_pkg and the wind_gust_vector_sum rtl
`timescale 1ns / 1ps

module tb_top;
    import wgvs_pkg::*;

    typedef struct {
        logic [15:0] speed;
        logic [15:0] azimuth;
        logic [31:0] stamp;
        logic        active;
    } wind_result_t;

    typedef struct {
        logic [31:0] regs [6];
        logic [31:0] stamp;
        bit          typed;
        logic [15:0] speed;
        logic [15:0] azimuth;
        logic        active;
    } wind_row_t;

    localparam longint KINV   = 64'sd652032874;
    localparam longint HALF_PI = 64'sd1686629713;
    localparam longint PI     = 64'sd3373259426;
    localparam longint AZ_MAX = 64'sd25736;
    localparam longint ARCTAN [24] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047,
        1023, 511, 255, 127};

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    cfg_index_t  cfg_addr;
    logic [31:0] cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // sim_time_ms
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // total_speed, total_azimuth, stamp_ms
    logic        m_axis_tuser;   // gust_active

    wind_gust_vector_sum dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // register copies
    longint      steady_spd, steady_az, gust_spd, gust_az;
    logic [31:0] gust_begin, gust_len;

    wind_result_t expected_wind [$];
    int          mismatches;
    bit          send_gaps;
    bit          recv_stalls;
    bit          hold_request;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("FAIL");
        $finish;
    end

    // speed*sin(az) into sx, speed*cos(az) into cy, q8.16 with the cordic gain prescaled out
    function automatic void rotate_into(input longint spd, input longint ang,
                                        inout longint sx, inout longint cy);
        longint c, s, z, dc, ds;
        c = (spd * 256 * KINV + (64'sd1 <<< 29)) >>> 30;
        s = 0;
        z = ang * 131072;
        if (z > HALF_PI)
        begin
            z = z - PI;
            c = -c;
        end
        else if (z < -HALF_PI)
        begin
            z = z + PI;
            c = -c;
        end
        for (int i = 0; i < NSTEPS; i++)
        begin
            dc = s >>> i;
            ds = c >>> i;
            if (z >= 0)
            begin
                c = c - dc;
                s = s + ds;
                z = z - ARCTAN[i];
            end
            else
            begin
                c = c + dc;
                s = s - ds;
                z = z + ARCTAN[i];
            end
        end
        sx = sx + s;
        cy = cy + c;
    endfunction

    function automatic wind_result_t predict_wind(input logic [31:0] stamp);
        wind_result_t r;
        longint sx, cy, px, py, z, dx, dy, spd, az;
        longint unsigned t, lo, hi;
        t  = stamp;
        lo = gust_begin;
        hi = lo + longint'(gust_len);
        r.active = (t >= lo) && (t < hi);
        r.stamp  = stamp;
        sx = 0;
        cy = 0;
        spd = 0;
        az = 0;
        rotate_into(steady_spd, steady_az, sx, cy);
        if (r.active)
            rotate_into(gust_spd, gust_az, sx, cy);
        if (sx != 0 || cy != 0)
        begin
            px = cy;
            py = sx;
            z  = 0;
            if (px < 0)
            begin
                z  = (py >= 0) ? PI : -PI;
                px = -px;
                py = -py;
            end
            for (int i = 0; i < NSTEPS; i++)
            begin
                dx = py >>> i;
                dy = px >>> i;
                if (py >= 0)
                begin
                    px = px + dx;
                    py = py - dy;
                    z  = z + ARCTAN[i];
                end
                else
                begin
                    px = px - dx;
                    py = py + dy;
                    z  = z - ARCTAN[i];
                end
            end
            if (px < 0)
                px = 0;
            spd = (px * KINV + (64'sd1 <<< 37)) >>> 38;
            if (spd > 65535)
                spd = 65535;
            az = (z + (64'sd1 <<< 16)) >>> 17;
            if (az > AZ_MAX)
                az = AZ_MAX;
            if (az < -AZ_MAX)
                az = -AZ_MAX;
        end
        r.speed   = spd[15:0];
        r.azimuth = az[15:0];
        return r;
    endfunction

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_STEADY_SPEED:   steady_spd = longint'($signed(val[15:0]));
            REG_STEADY_AZIMUTH: steady_az  = longint'($signed(val[15:0]));
            REG_GUST_SPEED:     gust_spd   = longint'($signed(val[15:0]));
            REG_GUST_AZIMUTH:   gust_az    = longint'($signed(val[15:0]));
            REG_GUST_START:     gust_begin = val;
            REG_GUST_LENGTH:    gust_len   = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic load_regs(input logic [31:0] regs [6]);
        write_reg(REG_STEADY_SPEED, regs[0]);
        write_reg(REG_STEADY_AZIMUTH, regs[1]);
        write_reg(REG_GUST_SPEED, regs[2]);
        write_reg(REG_GUST_AZIMUTH, regs[3]);
        write_reg(REG_GUST_START, regs[4]);
        write_reg(REG_GUST_LENGTH, regs[5]);
        cfg_we <= 1'b0;
    endtask

    // offer one stamp, push its expectation once the transfer happens
    task automatic send_stamp(input logic [31:0] stamp, input bit typed,
                              input wind_result_t known);
        wind_result_t e;
        if (send_gaps && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= stamp;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        e = typed ? known : predict_wind(stamp);
        expected_wind.push_back(e);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (expected_wind.size() != 0)
            @(posedge clk);
        repeat (2 * NSTEPS + 10) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_speed();
        case ($urandom_range(0, 5))
            0: return 32'h0000_8000;
            1: return 32'h0000_7fff;
            2: return 32'h0000_0000;
            default: return {16'h0, 16'($urandom())};
        endcase
    endfunction

    function automatic logic [31:0] pick_angle();
        case ($urandom_range(0, 6))
            0: return 32'(16'sd25736);
            1: return 32'(-16'sd25736);
            2: return 32'h0000_8000;
            3: return 32'h0000_7fff;
            4: return 32'(16'($urandom_range(0, 51472) - 25736));
            default: return {16'h0, 16'($urandom())};
        endcase
    endfunction

    function automatic logic [31:0] pick_stamp();
        case ($urandom_range(0, 7))
            0: return gust_begin;
            1: return gust_begin - 1;
            2: return gust_begin + gust_len;
            3: return gust_begin + gust_len - 1;
            4: return gust_begin + $urandom_range(0, 3000);
            5: return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
            default: return $urandom();
        endcase
    endfunction

    // receiver side
    initial
    begin
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                m_axis_tready <= 1'b0;
                repeat (150) @(posedge clk);
                hold_request = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else if (recv_stalls && $urandom_range(0, 6) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        wind_result_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_wind.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer data=%h", m_axis_tdata);
            end
            else
            begin
                e = expected_wind.pop_front();
                if (m_axis_tdata[15:0] !== e.speed || m_axis_tdata[31:16] !== e.azimuth
                    || m_axis_tdata[63:32] !== e.stamp || m_axis_tuser !== e.active)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch stamp %h: exp spd %h az %h act %b, got spd %h az %h stamp %h act %b",
                                 e.stamp, e.speed, e.azimuth, e.active, m_axis_tdata[15:0],
                                 m_axis_tdata[31:16], m_axis_tdata[63:32], m_axis_tuser);
                end
            end
        end
    end

    initial
    begin
        wind_row_t    rows [$];
        wind_row_t    r;
        wind_result_t known;
        logic [31:0]  regs [6];
        logic [31:0]  cur [6];
        int           count;

        mismatches    = 0;
        send_gaps     = 1'b0;
        recv_stalls   = 1'b0;
        hold_request  = 1'b0;
        steady_spd    = 0;
        steady_az     = 0;
        gust_spd      = 0;
        gust_az       = 0;
        gust_begin    = '0;
        gust_len      = '0;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_addr      <= REG_STEADY_SPEED;
        cfg_wdata     <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: regs, stamp, typed expectation where obvious
        rows = '{
            '{'{0, 0, 0, 0, 0, 0}, 32'h0, 1, 16'h0, 16'h0, 1'b0},
            '{'{0, 0, 0, 0, 0, 0}, 32'hffff_ffff, 1, 16'h0, 16'h0, 1'b0},
            '{'{0, 0, 1000, 100, 5, 0}, 32'h5, 1, 16'h0, 16'h0, 1'b0},
            '{'{256, 0, 0, 0, 100, 0}, 32'd100, 0, 0, 0, 0},
            '{'{256, 0, 32'h7fff, 25736, 100, 50}, 32'd99, 0, 0, 0, 0},
            '{'{256, 0, 32'h7fff, 25736, 100, 50}, 32'd100, 0, 0, 0, 0},
            '{'{256, 0, 32'h7fff, 25736, 100, 50}, 32'd149, 0, 0, 0, 0},
            '{'{256, 0, 32'h7fff, 25736, 100, 50}, 32'd150, 0, 0, 0, 0},
            '{'{32'h8000, 32'(-16'sd25736), 32'h7fff, 25736, 0, 32'hffff_ffff},
              32'h7fff_ffff, 0, 0, 0, 0},
            '{'{32'h7fff, 0, 32'h7fff, 0, 0, 10}, 32'd3, 0, 0, 0, 0},
            '{'{256, 0, 256, 25736, 0, 10}, 32'd3, 0, 0, 0, 0},
            '{'{1000, 12868, 32'hff00, 32'(-16'sd12868), 32'hffff_fff0, 32'hffff_ffff},
              32'hffff_ffff, 0, 0, 0, 0},
            '{'{1000, 12868, 32'hff00, 32'(-16'sd12868), 32'hffff_fff0, 32'hffff_ffff},
              32'h0, 0, 0, 0, 0},
            '{'{500, 32'h7fff, 700, 32'h8000, 0, 1}, 32'h0, 0, 0, 0, 0},
            '{'{500, 32'h8000, 700, 32'h7fff, 0, 1}, 32'h1, 0, 0, 0, 0},
            '{'{32'hff00, 32'(-16'sd6000), 0, 0, 0, 0}, 32'h1234_5678, 0, 0, 0, 0}
        };
        cur = '{0, 0, 0, 0, 0, 0};
        foreach (rows[i])
        begin
            r = rows[i];
            if (r.regs != cur)
            begin
                drain();
                load_regs(r.regs);
                cur = r.regs;
            end
            known = '{r.speed, r.azimuth, r.stamp, r.active};
            send_stamp(r.stamp, r.typed, known);
        end

        // random phases; the last runs without idling
        for (int phase = 0; phase < 9; phase++)
        begin
            drain();
            for (int k = 0; k < 6; k++)
                regs[k] = $urandom();
            regs[0] = pick_speed();
            regs[1] = pick_angle();
            regs[2] = pick_speed();
            regs[3] = pick_angle();
            case ($urandom_range(0, 3))
                0: regs[5] = 32'h0;
                1: regs[5] = 32'hffff_ffff;
                2: regs[5] = $urandom_range(1, 2000);
                default: ;
            endcase
            if (phase == 0)
                regs[4] = 32'hffff_ffff;
            load_regs(regs);
            send_gaps   = (phase < 8);
            recv_stalls = (phase < 8);
            count = 0;
            while (count < 180)
            begin
                if (phase == 2 && count == 40)
                    hold_request = 1'b1;
                if (phase == 4 && count == 90)
                    drain();
                send_stamp(pick_stamp(), 0, known);
                count++;
            end
        end

        drain();
        if (mismatches == 0 && expected_wind.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
